>>> hdl/bdh_pkg.sv
// Shared types and constants for the debounced button with hold detect.
// No dependencies; imported by every other file of the block.
package bdh_pkg;

    localparam int TimeW   = 32;
    localparam int DebW    = 16;
    localparam int MarksW  = 6;
    localparam int CfgIdxW = 1;
    localparam int CfgW    = 32;

    // Bit positions in the mark register
    localparam int MarkPressed = 0;
    localparam int MarkWas     = 1;
    localparam int MarkEvPress = 2;
    localparam int MarkEvRel   = 3;
    localparam int MarkHeld    = 4;
    localparam int MarkEvHold  = 5;

    localparam logic [DebW-1:0]  DebounceReset = DebW'(50);
    localparam logic [TimeW-1:0] HoldReset     = TimeW'(1000);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_HOLD     = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        KIND_PRESS = 1'b0,
        KIND_HOLD  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [DebW-1:0]  debounce_ms;
        logic [TimeW-1:0] hold_time_ms;
    } cfg_t;

    typedef struct packed {
        logic             kind;
        logic             pin_level;
        logic [TimeW-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic event_res;
        logic is_pressed;
        logic is_held;
    } res_t;

endpackage

>>> hdl/bdh_if.sv
// Valid/ready channel interfaces for query words and result words.
// Depends on bdh_pkg for widths.
interface bdh_in_if
    import bdh_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic             pin_level;
    logic [TimeW-1:0] now_ms;

    modport source (output valid, kind, pin_level, now_ms, input ready);
    modport sink   (input valid, kind, pin_level, now_ms, output ready);
endinterface

interface bdh_out_if;
    logic valid;
    logic ready;
    logic event_res;
    logic is_pressed;
    logic is_held;

    modport source (output valid, event_res, is_pressed, is_held, input ready);
    modport sink   (input valid, event_res, is_pressed, is_held, output ready);
endinterface

>>> hdl/bdh_cfg.sv
// Configuration registers: debounce time and hold time.
// Depends on bdh_pkg.
module bdh_cfg
    import bdh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_data,
    output cfg_t                cfg
);

    logic [DebW-1:0]  debounce_reg;
    logic [TimeW-1:0] hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DebounceReset;
            hold_reg     <= HoldReset;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DebW-1:0];
                CFG_HOLD:     hold_reg     <= cfg_data[TimeW-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg.debounce_ms  = debounce_reg;
    assign cfg.hold_time_ms = hold_reg;

endmodule

>>> hdl/bdh_core.sv
// Button state (marks, last change time) and the per-query update logic.
// Depends on bdh_pkg.
module bdh_core
    import bdh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    logic [MarksW-1:0] marks_reg, marks_next;
    logic [TimeW-1:0]  last_change_reg, last_change_next;

    logic [TimeW-1:0]  interval;
    logic [TimeW-1:0]  hold_ivl;
    logic              sample;
    logic [MarksW-1:0] m_smp;
    logic [MarksW-1:0] m_chg;
    logic [MarksW-1:0] m_hold;
    logic              ev_idx_hold;

    always_comb
    begin
        interval = item.now_ms - last_change_reg;
        sample   = interval > TimeW'(cfg.debounce_ms);

        // Debounced sample of the active-low pin
        m_smp = marks_reg;
        if (sample)
            m_smp[MarkPressed] = ~item.pin_level;

        // Press / release edge against the was-pressed mark
        m_chg            = m_smp;
        hold_ivl         = interval;
        last_change_next = last_change_reg;
        case ({m_smp[MarkWas], m_smp[MarkPressed]})
            2'b10:
            begin
                m_chg                = '0;
                m_chg[MarkEvRel]     = 1'b1;
                last_change_next     = item.now_ms;
            end
            2'b01:
            begin
                m_chg[MarkEvPress]   = 1'b1;
                m_chg[MarkWas]       = 1'b1;
                last_change_next     = item.now_ms;
                hold_ivl             = '0;
            end
            default: ;
        endcase

        m_hold = m_chg;
        if (m_chg[MarkPressed] && !m_chg[MarkHeld] && (hold_ivl > cfg.hold_time_ms))
        begin
            m_hold[MarkHeld]   = 1'b1;
            m_hold[MarkEvHold] = 1'b1;
        end

        // Report the queried event, then clear it
        ev_idx_hold = (kind_t'(item.kind) == KIND_HOLD);
        marks_next  = m_hold;
        if (ev_idx_hold)
        begin
            res.event_res          = m_hold[MarkEvHold];
            marks_next[MarkEvHold] = 1'b0;
        end
        else
        begin
            res.event_res           = m_hold[MarkEvPress];
            marks_next[MarkEvPress] = 1'b0;
        end
        res.is_pressed = marks_next[MarkPressed];
        res.is_held    = marks_next[MarkHeld];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg       <= '0;
            last_change_reg <= '0;
        end
        else if (fire)
        begin
            marks_reg       <= marks_next;
            last_change_reg <= last_change_next;
        end
    end

    // Held only ever stands together with pressed
    a_held_implies_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        marks_reg[MarkHeld] |-> marks_reg[MarkPressed])
        else $error("held mark without pressed mark");

    // State moves only when a query is processed
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(last_change_reg) && $stable(marks_reg))
        else $error("button state changed without a query");

    // A released button keeps no pending hold event and no held mark
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        !marks_reg[MarkPressed] |-> !marks_reg[MarkEvHold] && !marks_reg[MarkHeld])
        else $error("hold state left over after release");

endmodule

>>> hdl/button_debounce_hold_detect_top.sv
// Top level of the debounced button with press and long-hold detection.
// Depends on bdh_pkg, bdh_if, bdh_cfg and bdh_core.
//
//  channel  | dir | handshake     | word contents
//  ---------+-----+---------------+-------------------------------------------
//  in_ch    | in  | valid/ready   | kind, pin_level, now_ms
//  out_ch   | out | valid/ready   | event_res, is_pressed, is_held
//  cfg      | in  | cfg_we only   | cfg_index (0 debounce, 1 hold), cfg_data
//
// One query word per cycle sustained while out_ch does not stall; each word
// passes through the input register, then the result register.
// The mark and change-time update runs in the cycle a word leaves the input
// register, so the next word sees the updated state without a bubble.
// Reset clears the marks and change time and loads debounce 50, hold 1000.
// A stall on out_ch holds the result register; the input register keeps
// taking one more word, after which in_ch.ready drops until the stall ends.
module button_debounce_hold_detect_top
    import bdh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    bdh_in_if.sink              in_ch,
    bdh_out_if.source           out_ch,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_data
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  advance;

    bdh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Word moves from input register to result register when the latter is
    // free or being drained this cycle.
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.kind      <= in_ch.kind;
            item_reg.pin_level <= in_ch.pin_level;
            item_reg.now_ms    <= in_ch.now_ms;
        end
    end

    bdh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.event_res  = out_reg.event_res;
    assign out_ch.is_pressed = out_reg.is_pressed;
    assign out_ch.is_held    = out_reg.is_held;

    // A processed word always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word did not reach result register");

    // A waiting query is never dropped from the input register
    a_in_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending query lost");

    // A stalled result word stays put until it is taken
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result word changed");

endmodule

>>> tb/button_debounce_hold_detect_top_test.sv
`timescale 1ns / 100ps
// Testbench for button_debounce_hold_detect_top: directed and random query words,
// random gaps on both channels. Depends on bdh_pkg, bdh_if and the top module.
module button_debounce_hold_detect_top_test;
    import bdh_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgW-1:0]     cfg_data;

    bdh_in_if  in_ch ();
    bdh_out_if out_ch ();

    button_debounce_hold_detect_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block state and its registers, owned by the predictor.
    logic [MarksW-1:0] marks_q;
    logic [TimeW-1:0]  change_ms;
    logic [DebW-1:0]   deb_ms;
    logic [TimeW-1:0]  hold_ms;

    // Time of the last query word sent; random steps are taken from here.
    logic [TimeW-1:0]  clock_ms;

    res_t status_due[$];    // expected status words, oldest first
    int   mismatches;
    bit   no_gaps;          // when set, neither side idles

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop; the slowest correct run is well under a quarter of this.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps)
            return 0;
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Debounce, edge detect and hold detect for one query word. Updates the
    // mirrored marks and change time and returns the status word the block
    // should answer with.
    function automatic res_t debounce_and_hold(kind_t kind, logic pin, logic [TimeW-1:0] now);
        logic [TimeW-1:0]  span;
        logic [MarksW-1:0] m;
        res_t              r;
        int                ev_pos;
        span = now - change_ms;   // wraps, so a backward step reads as huge
        m    = marks_q;
        // Pin is only looked at once the debounce window has passed.
        if (span > {{(TimeW-DebW){1'b0}}, deb_ms})
            m[MarkPressed] = ~pin;
        case ({m[MarkWas], m[MarkPressed]})
            2'b10:
            begin
                // Release wipes everything, pending events included.
                m            = '0;
                m[MarkEvRel] = 1'b1;
                change_ms    = now;
            end
            2'b01:
            begin
                // Fresh press: hold timing starts from zero.
                m[MarkEvPress] = 1'b1;
                m[MarkWas]     = 1'b1;
                change_ms      = now;
                span           = '0;
            end
            default:
            begin
            end
        endcase
        if (m[MarkPressed] && !m[MarkHeld] && span > hold_ms)
        begin
            m[MarkHeld]   = 1'b1;
            m[MarkEvHold] = 1'b1;
        end
        ev_pos       = (kind == KIND_HOLD) ? MarkEvHold : MarkEvPress;
        r.event_res  = m[ev_pos];
        m[ev_pos]    = 1'b0;   // queried event is consumed
        r.is_pressed = m[MarkPressed];
        r.is_held    = m[MarkHeld];
        marks_q      = m;
        return r;
    endfunction

    // Result side: random backpressure, sometimes none for a stretch.
    initial
    begin : result_stall
        int hold_off;
        hold_off     = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_off--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold_off = pick_gap();
            end
        end
    end

    // Every accepted status word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $error("status word with nothing expected: event_res=%0b is_pressed=%0b is_held=%0b",
                       out_ch.event_res, out_ch.is_pressed, out_ch.is_held);
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                if (out_ch.event_res !== want.event_res)
                begin
                    $error("event_res: expected %0b, got %0b", want.event_res, out_ch.event_res);
                    mismatches++;
                end
                if (out_ch.is_pressed !== want.is_pressed)
                begin
                    $error("is_pressed: expected %0b, got %0b", want.is_pressed,
                           out_ch.is_pressed);
                    mismatches++;
                end
                if (out_ch.is_held !== want.is_held)
                begin
                    $error("is_held: expected %0b, got %0b", want.is_held, out_ch.is_held);
                    mismatches++;
                end
            end
        end
    end

    // Sends one query word. Called and returns at a falling edge; valid is
    // left high so back-to-back words go out without a bubble.
    task automatic send_word(input kind_t kind, input logic pin, input logic [TimeW-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.pin_level <= pin;
        in_ch.now_ms    <= now;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        status_due.push_back(debounce_and_hold(kind, pin, now));
        clock_ms = now;
        @(negedge clk);
    endtask

    // Stops sending and waits until every status word is back, then lets the
    // two pipeline stages settle before anything touches the registers.
    task automatic drain_queries();
        in_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Register write; only ever issued with the block idle.
    task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            deb_ms = data[DebW-1:0];
        else
            hold_ms = data;
        @(negedge clk);
    endtask

    // Reset values: press inside the debounce window is ignored, press after
    // it fires once, a bounce inside the window is ignored, hold fires once
    // past the hold time, then release clears it all.
    task automatic test_reset_defaults();
        send_word(KIND_PRESS, 1'b0, 32'd0);
        send_word(KIND_PRESS, 1'b0, 32'd10);
        send_word(KIND_PRESS, 1'b0, 32'd51);
        send_word(KIND_PRESS, 1'b1, 32'd60);
        send_word(KIND_HOLD,  1'b0, 32'd1051);
        send_word(KIND_HOLD,  1'b0, 32'd1052);
        send_word(KIND_PRESS, 1'b0, 32'd1053);
        send_word(KIND_HOLD,  1'b1, 32'd1200);
        send_word(KIND_PRESS, 1'b1, 32'd1300);
    endtask

    // Press just before the time wrap, release after it; backward steps.
    task automatic test_time_wrap();
        send_word(KIND_HOLD,  1'b0, 32'hFFFF_FFF0);
        send_word(KIND_PRESS, 1'b1, 32'h0000_0010);
        send_word(KIND_PRESS, 1'b1, 32'h0000_0040);
        send_word(KIND_PRESS, 1'b0, 32'h0000_0005);
        send_word(KIND_HOLD,  1'b0, 32'hFFFF_FFFF);
    endtask

    // Zero debounce and zero hold: same-time words are not sampled, one ms
    // later is; a new press never holds in the same word.
    task automatic test_zero_window();
        drain_queries();
        write_reg(CFG_DEBOUNCE, 32'h0000_0000);
        write_reg(CFG_HOLD,     32'h0000_0000);
        send_word(KIND_HOLD,  1'b1, clock_ms);
        send_word(KIND_HOLD,  1'b1, clock_ms + 32'd1);
        send_word(KIND_HOLD,  1'b0, clock_ms + 32'd1);
        send_word(KIND_HOLD,  1'b0, clock_ms + 32'd1);
        send_word(KIND_PRESS, 1'b0, clock_ms);
    endtask

    // Largest debounce (upper data bits set, must be ignored) and largest
    // hold, which can never be exceeded.
    task automatic test_config_extremes();
        drain_queries();
        write_reg(CFG_DEBOUNCE, 32'hFFFF_FFFF);
        write_reg(CFG_HOLD,     32'hFFFF_FFFF);
        send_word(KIND_PRESS, 1'b1, change_ms + 32'd65535);
        send_word(KIND_PRESS, 1'b1, change_ms + 32'd65536);
        send_word(KIND_HOLD,  1'b0, change_ms + 32'd65536);
        send_word(KIND_HOLD,  1'b0, change_ms + 32'hFFFF_FFFF);
    endtask

    // Mostly plausible button activity: time moves forward in small steps or
    // lands right on the debounce or hold boundary, the pin bounces. Eight in a
    // hundred of the words jump to an arbitrary time.
    task automatic test_random_traffic(input logic [DebW-1:0] deb, input logic [TimeW-1:0] hold,
                                       input int words);
        int              r;
        logic            pin;
        logic [TimeW-1:0] now;
        drain_queries();
        write_reg(CFG_DEBOUNCE, {16'($urandom()), deb});
        write_reg(CFG_HOLD, hold);
        pin = 1'b1;
        for (int i = 0; i < words; i++)
        begin
            if (i % 150 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35)
                now = clock_ms + $urandom_range(0, 3);
            else if (r < 60)
                now = change_ms + deb_ms + $urandom_range(0, 2);
            else if (r < 85)
                now = change_ms + hold_ms + $urandom_range(0, 2);
            else if (r < 92)
                now = clock_ms + $urandom_range(0, 5000);
            else
                now = $urandom();
            if ($urandom_range(0, 3) == 0)
                pin = ~pin;
            send_word(kind_t'($urandom_range(0, 1)), pin, now);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_DEBOUNCE;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_PRESS;
        in_ch.pin_level = 1'b1;
        in_ch.now_ms    = '0;
        marks_q         = '0;
        change_ms       = '0;
        deb_ms          = DebounceReset;
        hold_ms         = HoldReset;
        clock_ms        = '0;
        mismatches      = 0;
        no_gaps         = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_time_wrap();
        test_zero_window();
        test_config_extremes();
        test_random_traffic(DebounceReset, HoldReset, 305);
        test_random_traffic(16'd0, 32'd0, 305);
        test_random_traffic(16'hFFFF, 32'hFFFF_FFFF, 305);
        test_random_traffic(16'd3, 32'd25, 305);
        test_random_traffic(16'($urandom_range(0, 200)), $urandom_range(0, 2000), 305);
        test_random_traffic(16'($urandom()), $urandom(), 305);
        drain_queries();

        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
